/* rtl/sia_pkg.sv */
package sia_pkg;

  // store geometry
  localparam int unsigned DEPTH     = 16;
  localparam int unsigned WORD_BITS = 32;
  // count and index fields are fixed at 5 bits; DEPTH must stay below 32
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned IDX_W     = $clog2(DEPTH);

  typedef enum logic [2:0] {
    CMD_READ    = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_APPEND  = 3'd2,
    CMD_PREPEND = 3'd3,
    CMD_INSERT  = 3'd4,
    CMD_REMOVE  = 3'd5,
    CMD_RESIZE  = 3'd6,
    CMD_CLEAR   = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // what every cell sees each cycle
  typedef enum logic [1:0] {
    BC_NONE  = 2'd0,
    BC_FILL  = 2'd1,  // load value where lo <= i < hi
    BC_SHIFT = 2'd2   // load value at lo, take left word where lo < i <= hi
  } bcast_kind_e;

  typedef struct packed {
    bcast_kind_e            kind;
    logic [CNT_W-1:0]       lo;
    logic [CNT_W-1:0]       hi;
    logic [WORD_BITS-1:0]   value;
  } bcast_t;

endpackage

/* rtl/sia_cell.sv */
module sia_cell (
  input  logic                             clk_i,
  input  logic [sia_pkg::CNT_W-1:0]        pos_i,   // this cell's slot number
  input  sia_pkg::bcast_t                  bc_i,
  input  logic [sia_pkg::WORD_BITS-1:0]    left_i,  // word of slot pos_i-1
  output logic [sia_pkg::WORD_BITS-1:0]    word_o
);

  logic [sia_pkg::WORD_BITS-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    unique case (bc_i.kind)
      sia_pkg::BC_FILL: begin
        if (pos_i >= bc_i.lo && pos_i < bc_i.hi) word_d = bc_i.value;
      end
      sia_pkg::BC_SHIFT: begin
        if (pos_i == bc_i.lo) begin
          word_d = bc_i.value;
        end else if (pos_i > bc_i.lo && pos_i <= bc_i.hi) begin
          word_d = left_i;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

/* rtl/shift_insert_array.sv */
// channel   direction  handshake                 words
// --------  ---------  ------------------------  -------------------------------------
// command   in         in_valid_i / in_ready_o   cmd_i, index_i, value_i
// result    out        out_valid_o / out_ready_i read_value_o, count_o, is_empty_o,
//                                                front_value_o, back_value_o, status_o
//
// One command per cycle: every cell updates in the cycle it is accepted, so a
// prepend or insert shifts the whole row at once. The result register holds
// one word; a new command is taken when it is empty or being drained.
// Reset clears the count, the status and the result valid; cell contents are not reset.
// While a result stalls, no command is taken, so the state behind it holds.
module shift_insert_array (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [2:0]                              cmd_i,
  input  logic [sia_pkg::CNT_W-1:0]               index_i,
  input  logic signed [sia_pkg::WORD_BITS-1:0]    value_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [sia_pkg::WORD_BITS-1:0]    read_value_o,
  output logic [sia_pkg::CNT_W-1:0]               count_o,
  output logic                                    is_empty_o,
  output logic signed [sia_pkg::WORD_BITS-1:0]    front_value_o,
  output logic signed [sia_pkg::WORD_BITS-1:0]    back_value_o,
  output logic [1:0]                              status_o
);

  localparam logic [sia_pkg::CNT_W-1:0] DepthC = sia_pkg::CNT_W'(sia_pkg::DEPTH);
  localparam logic [sia_pkg::CNT_W-1:0] OneC   = sia_pkg::CNT_W'(1);

  logic [sia_pkg::WORD_BITS-1:0] cell_w [sia_pkg::DEPTH];

  logic                          out_valid_q;
  logic [sia_pkg::CNT_W-1:0]     count_q, count_d;
  logic [sia_pkg::WORD_BITS-1:0] read_q, read_d;
  sia_pkg::status_e              status_q, status_d;
  sia_pkg::bcast_t               bc;
  logic                          accept;
  logic                          empty;
  logic [sia_pkg::CNT_W-1:0]     back_pos;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // command decode into one broadcast for the row
  always_comb begin
    count_d  = count_q;
    read_d   = '0;
    status_d = sia_pkg::ST_OK;
    bc.kind  = sia_pkg::BC_NONE;
    bc.lo    = count_q;
    bc.hi    = count_q + OneC;
    bc.value = value_i;
    unique case (sia_pkg::cmd_e'(cmd_i))
      sia_pkg::CMD_READ: begin
        if (index_i >= count_q) status_d = sia_pkg::ST_RANGE;
        else read_d = cell_w[index_i[sia_pkg::IDX_W-1:0]];
      end
      sia_pkg::CMD_WRITE: begin
        if (index_i >= count_q) begin
          status_d = sia_pkg::ST_RANGE;
        end else begin
          bc.kind = sia_pkg::BC_FILL;
          bc.lo   = index_i;
          bc.hi   = index_i + OneC;
        end
      end
      sia_pkg::CMD_APPEND, sia_pkg::CMD_PREPEND, sia_pkg::CMD_INSERT: begin
        if (count_q >= DepthC) begin
          status_d = sia_pkg::ST_FULL;
        end else begin
          count_d = count_q + OneC;
          if (sia_pkg::cmd_e'(cmd_i) == sia_pkg::CMD_APPEND ||
              (sia_pkg::cmd_e'(cmd_i) == sia_pkg::CMD_INSERT && index_i >= count_q)) begin
            bc.kind = sia_pkg::BC_FILL;
          end else begin
            bc.kind = sia_pkg::BC_SHIFT;
            bc.lo   = (sia_pkg::cmd_e'(cmd_i) == sia_pkg::CMD_PREPEND) ? '0 : index_i;
            bc.hi   = count_q;
          end
        end
      end
      sia_pkg::CMD_REMOVE: begin
        if (count_q == '0) status_d = sia_pkg::ST_EMPTY;
        else count_d = count_q - OneC;
      end
      sia_pkg::CMD_RESIZE: begin
        if (index_i > DepthC) begin
          status_d = sia_pkg::ST_FULL;
        end else begin
          // shrinking leaves an empty fill range
          bc.kind = sia_pkg::BC_FILL;
          bc.hi   = index_i;
          count_d = index_i;
        end
      end
      sia_pkg::CMD_CLEAR: count_d = '0;
      default: count_d = count_q;
    endcase
    if (!accept) bc.kind = sia_pkg::BC_NONE;
  end

  // row of cells, each taking its left neighbor on a shift
  for (genvar g = 0; g < sia_pkg::DEPTH; g++) begin : g_cell
    logic [sia_pkg::WORD_BITS-1:0] left;
    if (g == 0) begin : g_head
      assign left = '0;
    end else begin : g_body
      assign left = cell_w[g-1];
    end
    sia_cell u_cell (
      .clk_i  (clk_i),
      .pos_i  (sia_pkg::CNT_W'(g)),
      .bc_i   (bc),
      .left_i (left),
      .word_o (cell_w[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
      status_q    <= sia_pkg::ST_OK;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
        status_q    <= status_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) read_q <= read_d;
  end

  // front/back come straight off the row; the row holds while a result waits
  assign empty         = (count_q == '0);
  assign back_pos      = count_q - OneC;
  assign out_valid_o   = out_valid_q;
  assign read_value_o  = read_q;
  assign count_o       = count_q;
  assign is_empty_o    = empty;
  assign status_o      = status_q;
  assign front_value_o = empty ? '0 : cell_w[0];
  assign back_value_o  = empty ? '0 : cell_w[back_pos[sia_pkg::IDX_W-1:0]];

  // count never passes depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("count above depth");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_i == sia_pkg::CMD_CLEAR |=> count_q == '0 && status_o == sia_pkg::ST_OK)
    else $error("clear did not empty the store");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && count_q == DepthC && cmd_i == sia_pkg::CMD_APPEND
    |=> status_o == sia_pkg::ST_FULL && count_q == $past(count_q))
    else $error("append on full store changed count");

  a_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_i == sia_pkg::CMD_REMOVE && count_q != '0
    |=> count_q == $past(count_q) - OneC)
    else $error("remove did not drop one entry");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(count_q) && $stable(back_value_o))
    else $error("state moved under a stalled result");

endmodule
